// ===== src/vst_pkg.sv =====
// Shared constants and types for the virtual segment translator.
// Used by vst_cell and virtual_segment_translator; no dependencies.
`default_nettype none

package vst_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int ALIGN_BITS  = 10;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ENTRY_W     = 4;

    localparam logic [31:0] RESET_VBASE = 32'd1048576;
    localparam logic [31:0] ALIGN_MASK  = 32'((64'd1 << ALIGN_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BADADDR = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        CMD_MAP     = 1'b0,
        CMD_RESOLVE = 1'b1
    } command_t;

    // lookup request walking down the cell chain
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [31:0]      addr;
        logic [IDX_W-1:0] idx;
        logic [31:0]      rbase;
        logic [31:0]      diff;
    } token_t;

    // entry write into one cell
    typedef struct packed {
        logic        we;
        logic [31:0] vbase;
        logic [31:0] rbase;
        logic [30:0] len;
    } entry_wr_t;

endpackage

`default_nettype wire

// ===== src/vst_cell.sv =====
// One table entry of the segment chain: holds base/length and checks the
// passing lookup request against it. Depends on vst_pkg.
`default_nettype none

module vst_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               live,
    input  wire vst_pkg::entry_wr_t wr,
    input  wire vst_pkg::token_t    tok_in,
    input  wire logic [vst_pkg::IDX_W-1:0] my_idx,
    output vst_pkg::token_t         tok_out
);

    logic [31:0]     vbase_reg;
    logic [31:0]     rbase_reg;
    logic [30:0]     len_reg;
    vst_pkg::token_t tok_reg;
    vst_pkg::token_t tok_next;
    logic [31:0]     diff;
    logic            match;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            vbase_reg <= wr.vbase;
            rbase_reg <= wr.rbase;
            len_reg   <= wr.len;
        end
    end

    // wrapped difference; a negative one has bit 31 set and never matches
    assign diff  = tok_in.addr - vbase_reg;
    assign match = live && !tok_in.hit && !diff[31] && (diff[30:0] < len_reg);

    always_comb begin
        tok_next = tok_in;
        if (match) begin
            tok_next.hit   = 1'b1;
            tok_next.idx   = my_idx;
            tok_next.rbase = rbase_reg;
            tok_next.diff  = diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_in.valid;
        end
        tok_reg.hit   <= tok_next.hit;
        tok_reg.addr  <= tok_next.addr;
        tok_reg.idx   <= tok_next.idx;
        tok_reg.rbase <= tok_next.rbase;
        tok_reg.diff  <= tok_next.diff;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== src/virtual_segment_translator.sv =====
// Base-and-bounds segment translator: top level with map control and a chain
// of vst_cell entries walked by each lookup. Depends on vst_pkg, vst_cell.
// A map request is registered in the pending stage, then moved to the output register on m_;
// a resolve passes the head register, each cell, the result add and the output register.
// One request is in flight at a time; the next is taken once its result has moved to the
// output register, so stalls on m_ also hold off the next request.
// Reset (aresetn low, synchronous) empties the table and reloads the next base.
`default_nettype none

module virtual_segment_translator (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // real_base, region_size, virt_addr, addr_offset, pad
    input  wire logic         s_tuser,  // command
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata,  // status, real_addr, assigned_base, entry_index, pad
    // configuration: first_virtual_base
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data
);

    localparam int N = vst_pkg::MAX_REGIONS;

    typedef struct packed {
        vst_pkg::status_t             status;
        logic [31:0]                  real_addr;
        logic [31:0]                  assigned;
        logic [vst_pkg::ENTRY_W-1:0]  index;
    } result_t;

    logic [31:0]             real_base;
    logic [30:0]             region_size;
    logic [31:0]             virt_addr;
    logic [31:0]             addr_offset;
    vst_pkg::command_t       command;

    logic                    accept;
    logic                    busy_reg, busy_next;
    logic [vst_pkg::CNT_W-1:0] count_reg, count_next;
    logic [31:0]             next_virt_reg, next_virt_next;
    vst_pkg::token_t         head_reg, head_next;
    vst_pkg::token_t         tok [N+1];
    vst_pkg::entry_wr_t      wr [N];
    logic [N-1:0]            live;
    logic [N:0]              tok_valid;

    logic                    pend_valid_reg, pend_valid_next;
    result_t                 pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg;
    logic                    move;

    logic                    map_bad, map_full, map_commit;
    logic [31:0]             aligned_next;

    assign real_base   = s_tdata[31:0];
    assign region_size = s_tdata[62:32];
    assign virt_addr   = s_tdata[94:63];
    assign addr_offset = s_tdata[126:95];
    assign command     = vst_pkg::command_t'(s_tuser);

    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign map_bad      = (region_size == 31'd0) || (real_base == 32'd0);
    assign map_full     = (count_reg >= vst_pkg::CNT_W'(N));
    assign map_commit   = accept && (command == vst_pkg::CMD_MAP) && !map_bad && !map_full;
    assign aligned_next = (next_virt_reg + {1'b0, region_size} + vst_pkg::ALIGN_MASK)
                          & ~vst_pkg::ALIGN_MASK;

    // ---------------- cell chain ----------------
    assign tok[0] = head_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        assign live[i]      = (count_reg > vst_pkg::CNT_W'(i));
        assign wr[i].we     = map_commit && (count_reg == vst_pkg::CNT_W'(i));
        assign wr[i].vbase  = next_virt_reg;
        assign wr[i].rbase  = real_base;
        assign wr[i].len    = region_size;
        assign tok_valid[i] = tok[i].valid;

        vst_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .live    (live[i]),
            .wr      (wr[i]),
            .tok_in  (tok[i]),
            .my_idx  (vst_pkg::IDX_W'(i)),
            .tok_out (tok[i+1])
        );
    end
    assign tok_valid[N] = tok[N].valid;

    // ---------------- control ----------------
    assign move = pend_valid_reg && (!out_valid_reg || m_tready);

    always_comb begin
        head_next       = head_reg;
        head_next.valid = 1'b0;
        if (accept && command == vst_pkg::CMD_RESOLVE) begin
            head_next.valid = 1'b1;
            head_next.hit   = 1'b0;
            head_next.addr  = virt_addr + addr_offset;
            head_next.idx   = '0;
            head_next.rbase = '0;
            head_next.diff  = '0;
        end
    end

    always_comb begin
        count_next     = count_reg;
        next_virt_next = next_virt_reg;
        if (map_commit) begin
            count_next     = count_reg + vst_pkg::CNT_W'(1);
            next_virt_next = aligned_next;
        end else if (cfg_valid && cfg_ready && count_reg == '0) begin
            next_virt_next = cfg_data;
        end
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (move) begin
            pend_valid_next = 1'b0;
        end
        if (accept && command == vst_pkg::CMD_MAP) begin
            pend_valid_next    = 1'b1;
            pend_next.real_addr = '0;
            pend_next.assigned  = '0;
            pend_next.index     = '0;
            priority if (map_bad) begin
                pend_next.status = vst_pkg::ST_INVALID;
            end else if (map_full) begin
                pend_next.status = vst_pkg::ST_FULL;
            end else begin
                pend_next.status   = vst_pkg::ST_OK;
                pend_next.assigned = next_virt_reg;
                pend_next.index    = vst_pkg::ENTRY_W'(count_reg);
            end
        end else if (tok[N].valid) begin
            pend_valid_next = 1'b1;
            if (tok[N].hit) begin
                pend_next.status    = vst_pkg::ST_OK;
                pend_next.real_addr = tok[N].rbase + tok[N].diff;
                pend_next.assigned  = '0;
                pend_next.index     = vst_pkg::ENTRY_W'(tok[N].idx);
            end else begin
                pend_next.status    = vst_pkg::ST_BADADDR;
                pend_next.real_addr = '0;
                pend_next.assigned  = '0;
                pend_next.index     = '0;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // busy from accept until the result leaves the pending stage
    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (move) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            next_virt_reg  <= vst_pkg::RESET_VBASE;
            head_reg.valid <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            count_reg      <= count_next;
            next_virt_reg  <= next_virt_next;
            head_reg.valid <= head_next.valid;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        head_reg.hit   <= head_next.hit;
        head_reg.addr  <= head_next.addr;
        head_reg.idx   <= head_next.idx;
        head_reg.rbase <= head_next.rbase;
        head_reg.diff  <= head_next.diff;
        pend_reg       <= pend_next;
        if (move) begin
            out_reg <= pend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.index, out_reg.assigned, out_reg.real_addr,
                       out_reg.status};

`ifndef SYNTHESIS
    // at most one lookup walks the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_valid) <= 1)
        else $error("more than one lookup in the cell chain");

    // idle block holds nothing in the chain or the pending stage
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (tok_valid == '0 && !pend_valid_reg && !head_reg.valid))
        else $error("work in flight while not busy");

    // table count never exceeds its depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= vst_pkg::CNT_W'(N))
        else $error("entry count beyond table depth");

    // a successful map bumps the count by one
    a_map_count: assert property (@(posedge aclk) disable iff (!aresetn)
        map_commit |=> count_reg == $past(count_reg) + vst_pkg::CNT_W'(1))
        else $error("map did not advance entry count");
`endif

endmodule

`default_nettype wire
